### design/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// shared types, constants and ring arithmetic for the double-ended queue
// ----------------------------------------------------------------------------
package deq_pkg;

	// ring depth and derived widths
	localparam int DEPTH   = 16;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int SUM_W   = CNT_W + 1;
	localparam int WORD_W  = 32;
	localparam int COUNT_W = 5;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [WORD_W-1:0] word_t;

	// command codes; codes above peek behave as peek
	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_PEEK       = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_POP_EMPTY = 2'd1,
		ST_PUSH_FULL = 2'd2
	} status_t;

	// ring store access for one request
	typedef struct packed {
		logic  wr_en;
		addr_t wr_addr;
		word_t wr_data;
		logic  rd_en;
		addr_t rd_front;
		addr_t rd_rear;
	} store_req_t;

	localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);

	// (base + off) mod DEPTH, with base < DEPTH and off <= DEPTH
	function automatic addr_t ring_add(input addr_t base, input cnt_t off);
		logic [SUM_W-1:0] s;
		s = SUM_W'(base) + SUM_W'(off);
		if (s >= DEPTH_S) begin
			s = s - DEPTH_S;
		end
		return ADDR_W'(s);
	endfunction

	// one step back around the ring
	function automatic addr_t ring_dec(input addr_t base);
		addr_t r;
		if (base == '0) begin
			r = ADDR_W'(DEPTH - 1);
		end else begin
			r = base - ADDR_W'(1);
		end
		return r;
	endfunction

	// one step forward around the ring
	function automatic addr_t ring_inc(input addr_t base);
		addr_t r;
		if (base == ADDR_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = base + ADDR_W'(1);
		end
		return r;
	endfunction

endpackage

### design/deq_store.sv
// ----------------------------------------------------------------------------
// deq_store
// word ring: one write port, two registered read ports
// ----------------------------------------------------------------------------
module deq_store (
	input  logic                clk,
	input  deq_pkg::store_req_t req,
	output deq_pkg::word_t      rd_front_data,
	output deq_pkg::word_t      rd_rear_data
);

	deq_pkg::word_t mem [deq_pkg::DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_front_data <= mem[req.rd_front];
			rd_rear_data  <= mem[req.rd_rear];
		end
	end

endmodule

### design/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// double_ended_queue_core
// bounded deque of signed 32-bit words kept in a ring store
// ----------------------------------------------------------------------------
//
// channel   | handshake           | payload
// ----------+---------------------+---------------------------------------------
// request   | start / busy        | command, value
// result    | done (1-cycle)      | front_value, rear_value, entry_count,
//           |                     | is_empty, status
//
// - a request is taken at an edge with start high and busy low
// - its result shows on the next cycle with done high, for that cycle only
// - busy is high during the result cycle, so no new request is taken while a result shows
// - the result cycle comes from the synchronous read of the ring store for the
//   new front and rear words
// - arst_n clears head, count and the strobe; the word store is not cleared
// - the receiver has no back-pressure; results are never held
//
module double_ended_queue_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         command,
	input  logic signed [31:0] value,
	output logic               done,
	output logic signed [31:0] front_value,
	output logic signed [31:0] rear_value,
	output logic [4:0]         entry_count,
	output logic               is_empty,
	output logic [1:0]         status
);

	// ring pointers
	deq_pkg::addr_t   head_q;
	deq_pkg::cnt_t    count_q;

	// result stage
	logic             done_s1;
	deq_pkg::status_t status_s1;
	logic             fwd_front_s1;
	logic             fwd_rear_s1;
	deq_pkg::word_t   val_s1;

	// next-state decode
	logic             accept;
	deq_pkg::addr_t   head_nx;
	deq_pkg::cnt_t    count_nx;
	deq_pkg::status_t status_nx;
	deq_pkg::store_req_t req;
	deq_pkg::word_t   rd_front_data;
	deq_pkg::word_t   rd_rear_data;
	deq_pkg::cnt_t    rear_off;

	assign accept = start && !busy;
	assign busy   = done_s1;

	// command decode and ring update
	always_comb begin
		head_nx     = head_q;
		count_nx    = count_q;
		status_nx   = deq_pkg::ST_OK;
		req.wr_en   = 1'b0;
		req.wr_addr = deq_pkg::ring_add(head_q, count_q);
		req.wr_data = deq_pkg::word_t'(value);
		unique case (command)
			deq_pkg::CMD_PUSH_FRONT: begin
				if (count_q == deq_pkg::CNT_W'(deq_pkg::DEPTH)) begin
					status_nx = deq_pkg::ST_PUSH_FULL;
				end else begin
					head_nx     = deq_pkg::ring_dec(head_q);
					count_nx    = count_q + deq_pkg::CNT_W'(1);
					req.wr_en   = accept;
					req.wr_addr = head_nx;
				end
			end
			deq_pkg::CMD_PUSH_BACK: begin
				if (count_q == deq_pkg::CNT_W'(deq_pkg::DEPTH)) begin
					status_nx = deq_pkg::ST_PUSH_FULL;
				end else begin
					count_nx  = count_q + deq_pkg::CNT_W'(1);
					req.wr_en = accept;
				end
			end
			deq_pkg::CMD_POP_FRONT: begin
				if (count_q == '0) begin
					status_nx = deq_pkg::ST_POP_EMPTY;
				end else begin
					head_nx  = deq_pkg::ring_inc(head_q);
					count_nx = count_q - deq_pkg::CNT_W'(1);
				end
			end
			deq_pkg::CMD_POP_BACK: begin
				if (count_q == '0) begin
					status_nx = deq_pkg::ST_POP_EMPTY;
				end else begin
					count_nx = count_q - deq_pkg::CNT_W'(1);
				end
			end
			default: begin
				// peek and unused codes leave the ring alone
			end
		endcase

		// read both ends as they stand after this request
		rear_off     = (count_nx == '0) ? '0 : count_nx - deq_pkg::CNT_W'(1);
		req.rd_en    = accept;
		req.rd_front = head_nx;
		req.rd_rear  = deq_pkg::ring_add(head_nx, rear_off);
	end

	deq_store u_store (
		.clk           (clk),
		.req           (req),
		.rd_front_data (rd_front_data),
		.rd_rear_data  (rd_rear_data)
	);

	// pointer state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
			if (accept) begin
				head_q  <= head_nx;
				count_q <= count_nx;
			end
		end
	end

	// payload of the result stage; forward the pushed word past the store
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1    <= status_nx;
			val_s1       <= req.wr_data;
			fwd_front_s1 <= req.wr_en && (req.wr_addr == req.rd_front);
			fwd_rear_s1  <= req.wr_en && (req.wr_addr == req.rd_rear);
		end
	end

	// result ports
	assign done        = done_s1;
	assign is_empty    = (count_q == '0);
	assign entry_count = deq_pkg::COUNT_W'(count_q);
	assign status      = status_s1;
	assign front_value = is_empty     ? '1 :
	                     fwd_front_s1 ? val_s1 : rd_front_data;
	assign rear_value  = is_empty     ? '1 :
	                     fwd_rear_s1  ? val_s1 : rd_rear_data;

	// every result comes from a request taken the edge before
	a_done_follows_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result without a request");

	// a taken request always yields a result next cycle
	a_req_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("request lost");

	// a rejected push only happens on a full ring
	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_s1 == deq_pkg::ST_PUSH_FULL) |->
		(count_q == deq_pkg::CNT_W'(deq_pkg::DEPTH)))
		else $error("push rejected while not full");

	// an ignored pop leaves the ring empty
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_s1 == deq_pkg::ST_POP_EMPTY) |-> is_empty)
		else $error("pop flagged empty on a non-empty ring");

endmodule
